// File: hdl/flep_pkg.sv
package flep_pkg;

  typedef enum logic [1:0] {
    LS_DISCONNECTED = 2'd0,
    LS_DISCOVERY    = 2'd1,
    LS_TRANSMITTING = 2'd2,
    LS_SUSPECT      = 2'd3
  } link_state_t;

  typedef enum logic [2:0] {
    FLT_CLEAR        = 3'd0,
    FLT_BAD_PATH     = 3'd1,
    FLT_BAD_MASK     = 3'd2,
    FLT_BAD_CHECKSUM = 3'd3,
    FLT_LOST_HOST    = 3'd4
  } fault_t;

  localparam logic [7:0] HEADER_BASE = 8'hF0;
  localparam logic [7:0] TRAILER     = 8'hBF;
  localparam logic [1:0] MISS_LIMIT  = 2'd3;

  typedef struct packed {
    logic hs_ok;
    logic path_ok;
    logic mask_ok;
    logic sum_ok;
  } rx_check_t;

  function automatic logic [7:0] byte_of(input logic [63:0] frame, input logic [2:0] idx);
    byte_of = frame[8*(7-idx) +: 8];
  endfunction

endpackage

// File: hdl/flep_in_if.sv
interface flep_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] tx_data;
  logic        [63:0] rx_frame;

  modport source (output valid, output tx_data, output rx_frame, input ready);
  modport sink   (input valid, input tx_data, input rx_frame, output ready);
endinterface

// File: hdl/flep_out_if.sv
interface flep_out_if;
  logic               valid;
  logic               ready;
  logic        [63:0] tx_frame;
  logic               tx_sent;
  logic signed [31:0] return_value;
  logic        [1:0]  link_status;
  logic        [2:0]  fault_code;
  logic        [2:0]  path_number;

  modport source (output valid, output tx_frame, output tx_sent, output return_value,
                  output link_status, output fault_code, output path_number, input ready);
  modport sink   (input valid, input tx_frame, input tx_sent, input return_value,
                  input link_status, input fault_code, input path_number, output ready);
endinterface

// File: hdl/flep_frame_unit.sv
module flep_frame_unit import flep_pkg::*; (
  input  logic [2:0]  path,
  input  logic [7:0]  mask,
  input  logic [31:0] word,
  input  logic [63:0] rx_frame,
  output logic [63:0] tx_frame,
  output rx_check_t   chk
);

  logic [7:0] tx_sum;
  logic [7:0] rx_sum;
  logic [7:0] header;

  assign header = HEADER_BASE | {5'd0, path};
  assign tx_sum = header + mask + word[31:24] + word[23:16] + word[15:8] + word[7:0];
  assign tx_frame = {header, mask, word, tx_sum, TRAILER};

  assign rx_sum = byte_of(rx_frame, 3'd1) + byte_of(rx_frame, 3'd2) + byte_of(rx_frame, 3'd3)
                + byte_of(rx_frame, 3'd4) + byte_of(rx_frame, 3'd5) + byte_of(rx_frame, 3'd6);

  assign chk.sum_ok  = (rx_sum == byte_of(rx_frame, 3'd7));
  assign chk.hs_ok   = (byte_of(rx_frame, 3'd0) == TRAILER) && chk.sum_ok;
  assign chk.path_ok = (rx_frame[50:48] == path);
  assign chk.mask_ok = (byte_of(rx_frame, 3'd2) == mask);

endmodule

// File: hdl/framed_link_endpoint.sv
// Each input beat is registered in the input stage; its result is computed from that stage and
// registered in the output stage, which offers it until it is taken.
// Throughput: one beat per cycle. While a result waits, the input register can still take
// one further beat, and the input then stalls until the waiting result is taken.
// Reset is synchronous and active low: the link goes to disconnected, the fault to lost
// host, the path, miss count and mask to zero, and both stages are emptied.
module framed_link_endpoint import flep_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  flep_in_if.sink     in_chan,
  flep_out_if.source  out_chan
);

  logic [7:0]  module_mask_r;
  logic        s1_valid_r;
  logic [31:0] s1_tx_data_r;
  logic [63:0] s1_rx_frame_r;
  logic        out_valid_r;
  logic        advance;

  link_state_t state_r, state_nxt;
  fault_t      fault_r, fault_nxt;
  logic        pws_r, pws_nxt;
  logic [1:0]  miss_r, miss_nxt;
  logic [2:0]  path_r, path_nxt;

  logic [31:0] word;
  logic [63:0] built_frame;
  rx_check_t   chk;
  logic        sent;
  logic [31:0] ret;

  logic [63:0] tx_frame_r;
  logic        tx_sent_r;
  logic [31:0] ret_r;

  assign advance = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      module_mask_r <= 8'd0;
    end else if (cfg_we) begin
      module_mask_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_tx_data_r  <= in_chan.tx_data;
      s1_rx_frame_r <= in_chan.rx_frame;
    end
  end

  assign word = (state_r == LS_TRANSMITTING) ? s1_tx_data_r : 32'd0;

  flep_frame_unit u_frame (
    .path     (path_r),
    .mask     (module_mask_r),
    .word     (word),
    .rx_frame (s1_rx_frame_r),
    .tx_frame (built_frame),
    .chk      (chk)
  );

  always_comb begin
    state_nxt = state_r;
    fault_nxt = fault_r;
    pws_nxt   = pws_r;
    miss_nxt  = miss_r;
    path_nxt  = path_r;
    sent      = 1'b0;
    ret       = 32'd0;
    case (state_r)
      LS_DISCOVERY: begin
        sent = 1'b1;
        if (chk.hs_ok) begin
          path_nxt  = s1_rx_frame_r[50:48];
          state_nxt = LS_TRANSMITTING;
        end else begin
          state_nxt = LS_DISCONNECTED;
          pws_nxt   = 1'b0;
        end
      end
      LS_TRANSMITTING: begin
        sent = 1'b1;
        if (chk.path_ok && chk.mask_ok && chk.sum_ok) begin
          fault_nxt = FLT_CLEAR;
          pws_nxt   = 1'b0;
          miss_nxt  = 2'd0;
          ret       = s1_rx_frame_r[39:8];
        end else begin
          state_nxt = LS_SUSPECT;
          pws_nxt   = 1'b1;
          if (!chk.path_ok) begin
            fault_nxt = FLT_BAD_PATH;
          end else if (!chk.sum_ok) begin
            fault_nxt = FLT_BAD_CHECKSUM;
          end else begin
            fault_nxt = FLT_BAD_MASK;
          end
        end
      end
      LS_SUSPECT: begin
        if (pws_r && (miss_r == MISS_LIMIT)) begin
          state_nxt = LS_DISCONNECTED;
          fault_nxt = FLT_LOST_HOST;
        end else begin
          if (miss_r != MISS_LIMIT) begin
            miss_nxt = miss_r + 2'd1;
          end
          state_nxt = LS_TRANSMITTING;
        end
      end
      default: begin
        state_nxt = LS_DISCOVERY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= LS_DISCONNECTED;
      fault_r     <= FLT_LOST_HOST;
      pws_r       <= 1'b0;
      miss_r      <= 2'd0;
      path_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        state_r <= state_nxt;
        fault_r <= fault_nxt;
        pws_r   <= pws_nxt;
        miss_r  <= miss_nxt;
        path_r  <= path_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx_frame_r <= sent ? built_frame : 64'd0;
      tx_sent_r  <= sent;
      ret_r      <= ret;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.tx_frame     = tx_frame_r;
  assign out_chan.tx_sent      = tx_sent_r;
  assign out_chan.return_value = ret_r;
  assign out_chan.link_status  = state_r;
  assign out_chan.fault_code   = fault_r;
  assign out_chan.path_number  = path_r;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import flep_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int BEATS_PER_PHASE = 475;

  typedef struct packed {
    logic signed [31:0] tx_data;
    logic [63:0]        rx_frame;
  } link_item_t;

  typedef struct packed {
    logic [63:0]        tx_frame;
    logic               tx_sent;
    logic signed [31:0] return_value;
    link_state_t        link_status;
    fault_t             fault_code;
    logic [2:0]         path_number;
  } link_result_t;

  typedef struct {
    link_item_t   item;
    bit           pinned;
    link_result_t pinned_result;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  flep_in_if  in_if ();
  flep_out_if out_if ();

  framed_link_endpoint uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  link_state_t  lk_state;
  logic         lk_prev_suspect;
  logic [1:0]   lk_missed;
  logic [2:0]   lk_path;
  fault_t       lk_fault;
  logic [7:0]   lk_mask;

  link_result_t link_results_due[$];
  script_row_t  script[$];

  int  mismatch_count = 0;
  int  beats_in = 0;
  int  cycles = 0;
  int  good_replies = 0;
  int  reply_faults = 0;
  int  host_losses = 0;
  int  mask_settings = 0;
  bit  quiet = 1'b0;
  bit  pressure_done = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] sum_range(input logic [63:0] f, input int first,
                                           input int last);
    logic [7:0] s;
    s = 8'h00;
    for (int i = first; i <= last; i++) s += f[8*(7-i) +: 8];
    return s;
  endfunction

  function automatic logic [63:0] seal_frame(input logic [63:0] f);
    return {f[63:8], sum_range(f, 1, 6)};
  endfunction

  function automatic logic [63:0] frame_out(input logic [31:0] word);
    logic [63:0] f;
    f = {HEADER_BASE | {5'b00000, lk_path}, lk_mask, word, 8'h00, TRAILER};
    f[15:8] = sum_range(f, 0, 5);
    return f;
  endfunction

  function automatic link_result_t advance_link(input link_item_t it);
    link_result_t r;
    logic [63:0]  rx;
    logic         path_ok;
    logic         mask_ok;
    logic         sum_ok;
    r = '0;
    rx = it.rx_frame;
    case (lk_state)
      LS_DISCOVERY: begin
        r.tx_frame = frame_out(32'h0);
        r.tx_sent = 1'b1;
        if (rx[63:56] == TRAILER && sum_range(rx, 1, 6) == rx[7:0]) begin
          lk_path = rx[50:48];
          lk_state = LS_TRANSMITTING;
        end else begin
          lk_state = LS_DISCONNECTED;
          lk_prev_suspect = 1'b0;
        end
      end
      LS_TRANSMITTING: begin
        r.tx_frame = frame_out(it.tx_data);
        r.tx_sent = 1'b1;
        path_ok = rx[50:48] == lk_path;
        mask_ok = rx[47:40] == lk_mask;
        sum_ok = sum_range(rx, 1, 6) == rx[7:0];
        if (path_ok && mask_ok && sum_ok) begin
          lk_fault = FLT_CLEAR;
          lk_prev_suspect = 1'b0;
          lk_missed = 2'd0;
          r.return_value = rx[39:8];
          good_replies++;
        end else begin
          lk_state = LS_SUSPECT;
          lk_prev_suspect = 1'b1;
          reply_faults++;
          if (!path_ok) lk_fault = FLT_BAD_PATH;
          else if (!sum_ok) lk_fault = FLT_BAD_CHECKSUM;
          else lk_fault = FLT_BAD_MASK;
        end
      end
      LS_SUSPECT: begin
        if (lk_prev_suspect && lk_missed == MISS_LIMIT) begin
          lk_state = LS_DISCONNECTED;
          lk_fault = FLT_LOST_HOST;
          host_losses++;
        end else begin
          if (lk_missed != MISS_LIMIT) lk_missed++;
          lk_state = LS_TRANSMITTING;
        end
      end
      default: begin
        lk_state = LS_DISCOVERY;
      end
    endcase
    r.link_status = lk_state;
    r.fault_code = lk_fault;
    r.path_number = lk_path;
    return r;
  endfunction

  function automatic link_item_t random_item();
    link_item_t  it;
    int          pick;
    logic [63:0] f;
    it.tx_data = $urandom;
    it.rx_frame = {$urandom, $urandom};
    pick = $urandom_range(99);
    case (lk_state)
      LS_DISCOVERY: begin
        f = seal_frame({TRAILER, it.rx_frame[55:0]});
        if (pick < 80) it.rx_frame = f;
        else if (pick < 90) it.rx_frame = f ^ {56'h0, 8'($urandom_range(1, 255))};
      end
      LS_TRANSMITTING: begin
        f = seal_frame({it.rx_frame[63:51], lk_path, lk_mask, it.rx_frame[39:0]});
        if (pick < 82) begin
          it.rx_frame = f;
        end else if (pick < 87) begin
          f[50:48] = lk_path ^ 3'($urandom_range(1, 7));
          it.rx_frame = seal_frame(f);
        end else if (pick < 92) begin
          f[47:40] = lk_mask ^ 8'($urandom_range(1, 255));
          it.rx_frame = seal_frame(f);
        end else if (pick < 96) begin
          it.rx_frame = f ^ {56'h0, 8'($urandom_range(1, 255))};
        end
      end
      default: begin
      end
    endcase
    return it;
  endfunction

  function automatic link_result_t pin(input logic [63:0] frame, input logic sent,
                                       input link_state_t status, input fault_t fault,
                                       input logic [2:0] path);
    link_result_t r;
    r = '0;
    r.tx_frame = frame;
    r.tx_sent = sent;
    r.link_status = status;
    r.fault_code = fault;
    r.path_number = path;
    return r;
  endfunction

  task automatic add_row(input logic [31:0] tx, input logic [63:0] rx, input bit pinned,
                         input link_result_t res);
    script_row_t row;
    row.item.tx_data = tx;
    row.item.rx_frame = rx;
    row.pinned = pinned;
    row.pinned_result = res;
    script.push_back(row);
  endtask

  task automatic build_script();
    link_result_t none;
    none = '0;
    add_row(32'h0, 64'h0123_4567_89AB_CDEF, 1'b1,
            pin(64'h0, 1'b0, LS_DISCOVERY, FLT_LOST_HOST, 3'd0));
    add_row(32'h0, 64'h0, 1'b1,
            pin(64'hF000_0000_0000_F0BF, 1'b1, LS_DISCONNECTED, FLT_LOST_HOST, 3'd0));
    add_row(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, none);
    add_row(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, none);
    add_row(32'h0, 64'h0, 1'b0, none);
    add_row(32'h0, seal_frame({8'hBF, 8'h05, 40'h11_2233_4455, 8'h00}) ^ 64'hFF, 1'b0, none);
    add_row(32'h0, 64'h0, 1'b0, none);
    add_row(32'h0, seal_frame({8'hBF, 8'hFD, 40'h01_2345_6789, 8'h00}), 1'b0, none);
    add_row(32'h7FFF_FFFF, seal_frame({8'h00, 8'h05, 8'h00, 32'h7FFF_FFFF, 8'h00}),
            1'b0, none);
    add_row(32'h8000_0000, seal_frame({8'h00, 8'hF5, 8'h00, 32'h8000_0000, 8'h00}),
            1'b0, none);
    add_row(32'hFFFF_FFFF, seal_frame({8'hFF, 8'h0D, 8'h00, 32'hFFFF_FFFF, 8'h00}),
            1'b0, none);
    add_row(32'h0, seal_frame({8'h00, 8'h04, 8'h00, 32'h1234_5678, 8'h00}), 1'b1,
            pin(64'hF500_0000_0000_F5BF, 1'b1, LS_SUSPECT, FLT_BAD_PATH, 3'd5));
    add_row(32'h0, 64'h0, 1'b0, none);
    add_row(32'h5555_AAAA, seal_frame({8'h00, 8'h05, 8'h00, 32'h0BAD_F00D, 8'h00}) ^ 64'h1,
            1'b0, none);
    add_row(32'h0, 64'h0, 1'b0, none);
    add_row(32'hAAAA_5555, seal_frame({8'h00, 8'h05, 8'h01, 32'h0000_FFFF, 8'h00}),
            1'b0, none);
    add_row(32'h0, 64'h0, 1'b0, none);
    add_row(32'h1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, none);
    add_row(32'h0, 64'h0, 1'b1, pin(64'h0, 1'b0, LS_DISCONNECTED, FLT_LOST_HOST, 3'd5));
    add_row(32'h0, 64'h0, 1'b0, none);
    add_row(32'h0, seal_frame({8'hBF, 8'h02, 40'hFF_FFFF_FFFF, 8'h00}), 1'b0, none);
    add_row(32'h2468_ACE0, seal_frame({8'h00, 8'h02, 8'h80, 32'hCAFE_F00D, 8'h00}) ^ 64'h80,
            1'b0, none);
    add_row(32'h0, 64'h0, 1'b1, pin(64'h0, 1'b0, LS_DISCONNECTED, FLT_LOST_HOST, 3'd2));
    add_row(32'h0, 64'h0, 1'b0, none);
    add_row(32'h0, seal_frame({8'hBF, 8'h07, 40'h00_0000_0000, 8'h00}), 1'b0, none);
    add_row(32'h1357_9BDF, seal_frame({8'h5A, 8'h07, 8'h00, 32'h0000_0001, 8'h00}),
            1'b0, none);
    add_row(32'h0, seal_frame({8'h00, 8'h07, 8'hFF, 32'h0, 8'h00}), 1'b0, none);
    add_row(32'h0, 64'h0, 1'b0, none);
  endtask

  task automatic offer_beat(input link_item_t it, input bit pinned, input link_result_t res);
    link_result_t r;
    in_if.valid <= 1'b1;
    in_if.tx_data <= it.tx_data;
    in_if.rx_frame <= it.rx_frame;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    r = advance_link(it);
    link_results_due.push_back(pinned ? res : r);
    beats_in++;
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(99) < 7) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_and_set_mask(input logic [7:0] value);
    in_if.valid <= 1'b0;
    while (link_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    lk_mask = value;
    mask_settings++;
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    link_result_t want;
    if (link_results_due.size() == 0) begin
      $display("%0t result beat with nothing expected, tx_frame %h", $time, out_if.tx_frame);
      mismatch_count++;
    end else begin
      want = link_results_due.pop_front();
      report_field("tx_frame", want.tx_frame, out_if.tx_frame);
      report_field("tx_sent", want.tx_sent, out_if.tx_sent);
      report_field("return_value", want.return_value, out_if.return_value);
      report_field("link_status", want.link_status, out_if.link_status);
      report_field("fault_code", want.fault_code, out_if.fault_code);
      report_field("path_number", want.path_number, out_if.path_number);
    end
  endtask

  initial begin
    int hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) check_result();
      if (!pressure_done && beats_in >= 1200) begin
        hold = 80;
        pressure_done = 1'b1;
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= !(!quiet && $urandom_range(99) < 7);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [7:0] masks [4];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 8'h00;
    in_if.valid = 1'b0;
    in_if.tx_data = '0;
    in_if.rx_frame = '0;
    lk_state = LS_DISCONNECTED;
    lk_prev_suspect = 1'b0;
    lk_missed = 2'd0;
    lk_path = 3'd0;
    lk_fault = FLT_LOST_HOST;
    lk_mask = 8'h00;
    masks[0] = 8'hFF;
    masks[1] = 8'($urandom_range(1, 254));
    masks[2] = 8'h00;
    masks[3] = 8'($urandom_range(1, 254));
    build_script();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    drain_and_set_mask(8'h00);
    foreach (script[i]) begin
      offer_beat(script[i].item, script[i].pinned, script[i].pinned_result);
      sender_gap();
    end
    for (int p = 0; p < 4; p++) begin
      drain_and_set_mask(masks[p]);
      quiet = (p == 1);
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        offer_beat(random_item(), 1'b0, '0);
        sender_gap();
      end
      quiet = 1'b0;
    end
    in_if.valid <= 1'b0;
    while (link_results_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("%0d input beats checked under %0d module mask settings.", beats_in,
             mask_settings);
    $display("%0d good replies, %0d faulty replies, %0d lost-host disconnects.",
             good_replies, reply_faults, host_losses);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
